@@ hdl/positional_list_engine_top_macros.svh @@
// Assertion macros for the positional list engine checker
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ple_pkg.sv @@
// Shared types and constants for the positional list engine
package ple_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 8;
    localparam int POS_W  = 7;
    localparam int CMD_W  = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCNT_W = 7;
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // decoded operation for one item
    typedef struct packed {
        logic    ins;
        logic    del;
        logic    fetch;
        status_t status;
    } ple_op_t;

    // per-cell update control
    typedef struct packed {
        logic load;
        logic take_prev;
        logic take_next;
    } ple_cell_ctl_t;

endpackage

@@ hdl/ple_cell.sv @@
// One list entry: loads, shifts back from the previous cell or forward from the next
module ple_cell
    import ple_pkg::*;
(
    input  logic              clk,
    input  ple_cell_ctl_t     ctl,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] d_prev,
    input  logic [DATA_W-1:0] d_next,
    output logic [DATA_W-1:0] q
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb
    begin
        priority if (ctl.load)
            entry_next = value;
        else if (ctl.take_prev)
            entry_next = d_prev;
        else if (ctl.take_next)
            entry_next = d_next;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

@@ hdl/ple_decode.sv @@
// Command decode: range checks against the current count, status and operation
module ple_decode
    import ple_pkg::*;
(
    input  logic [CMD_W-1:0] command,
    input  logic [POS_W-1:0] position,
    input  logic [CNT_W-1:0] cnt,
    output ple_op_t          op
);

    logic [CMP_W-1:0] pos_e;
    logic [CMP_W-1:0] cnt_e;

    assign pos_e = CMP_W'(position);
    assign cnt_e = CMP_W'(cnt);

    always_comb
    begin
        op = '{ins: 1'b0, del: 1'b0, fetch: 1'b0, status: ST_INVALID};
        unique case (cmd_t'(command))
            CMD_INSERT:
            begin
                if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1))
                    op.status = ST_INVALID;
                else if (cnt_e == CMP_W'(DEPTH))
                    op.status = ST_FULL;
                else
                begin
                    op.status = ST_OK;
                    op.ins    = 1'b1;
                end
            end
            CMD_DELETE, CMD_READ:
            begin
                // empty check wins over the position check
                if (cnt_e == '0)
                    op.status = ST_EMPTY;
                else if (pos_e == '0 || pos_e > cnt_e)
                    op.status = ST_INVALID;
                else
                begin
                    op.status = ST_OK;
                    op.fetch  = 1'b1;
                    op.del    = (cmd_t'(command) == CMD_DELETE);
                end
            end
            default:
                op.status = ST_INVALID;
        endcase
    end

endmodule

@@ hdl/positional_list_engine_top.sv @@
// Positional list engine top level: decode, row of entry cells, result register
//
// Ordered list of up to DEPTH bytes held in a row of cells, one byte per cell.
// An item is taken in the cycle its handshake completes: decode checks the
// command and 1-based position against the current count, every cell shifts,
// loads or holds in that same cycle, and the result lands in the output
// register at the next edge. One item per cycle; in_ready stays high while the
// output register is empty or its result is being taken. Insert and delete
// move all later entries at once along the cell row, so cost does not grow
// with position. Entries are not cleared at reset and need no clearing pass:
// only positions 1..count are ever read.
module positional_list_engine_top
    import ple_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [POS_W-1:0]  position,
    input  logic [DATA_W-1:0] value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] data,
    output logic [1:0]        status,
    output logic [OCNT_W-1:0] count
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] data_reg;
    status_t           status_reg;
    logic [OCNT_W-1:0] count_out_reg;

    logic              accept;
    ple_op_t           op;
    logic [CMP_W-1:0]  pos_e;
    logic [DATA_W-1:0] cell_q   [DEPTH];
    logic [DATA_W-1:0] cell_sel [DEPTH];
    logic [DATA_W-1:0] fetched;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign pos_e    = CMP_W'(position);

    ple_decode u_decode (
        .command  (command),
        .position (position),
        .cnt      (count_reg),
        .op       (op)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] CELL_POS = CMP_W'(i + 1);
        ple_cell_ctl_t     ctl;
        logic [DATA_W-1:0] d_prev;
        logic [DATA_W-1:0] d_next;

        assign ctl.load      = accept && op.ins && (pos_e == CELL_POS);
        assign ctl.take_prev = accept && op.ins && (pos_e < CELL_POS);
        assign ctl.take_next = accept && op.del && (pos_e <= CELL_POS);

        if (i == 0)
        begin : g_first
            assign d_prev = '0;
        end
        else
        begin : g_mid_prev
            assign d_prev = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign d_next = '0;
        end
        else
        begin : g_mid_next
            assign d_next = cell_q[i+1];
        end

        ple_cell u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .value  (value),
            .d_prev (d_prev),
            .d_next (d_next),
            .q      (cell_q[i])
        );

        assign cell_sel[i] = (pos_e == CELL_POS) ? cell_q[i] : '0;
    end

    // one cell at most matches the position
    always_comb
    begin
        fetched = '0;
        for (int k = 0; k < DEPTH; k++)
            fetched = fetched | cell_sel[k];
    end

    always_comb
    begin
        priority if (op.ins)
            count_next = count_reg + CNT_W'(1);
        else if (op.del)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg      <= op.fetch ? fetched : '0;
            status_reg    <= op.status;
            count_out_reg <= OCNT_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

endmodule

@@ hdl/ple_checker.sv @@
// Port-level checker for the positional list engine, bound to the top level
`include "positional_list_engine_top_macros.svh"

module ple_checker
    import ple_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] data,
    input logic [1:0]        status,
    input logic [OCNT_W-1:0] count
);

    localparam logic [OCNT_W-1:0] FULL_CNT = OCNT_W'(DEPTH);

    `PLE_ASSERT_NEXT(a_item_gives_result, in_valid && in_ready, out_valid,
                     "accepted item left no result")

    `PLE_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
                     out_valid && $stable(data) && $stable(status) && $stable(count),
                     "stalled result changed")

    `PLE_ASSERT_NOW(a_error_zero_data, out_valid && status != ST_OK, data == '0,
                    "error result carries data")

    `PLE_ASSERT_NOW(a_full_count, out_valid && status == ST_FULL, count == FULL_CNT,
                    "full status without a full list")

    `PLE_ASSERT_NOW(a_ready_when_free, !out_valid, in_ready,
                    "not ready with an empty result register")

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the positional list engine: directed and random list traffic
`timescale 1ns / 100ps

module testbench;
    import ple_pkg::*;

    localparam int GAP_MAX      = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 30;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        status_t           status;
        logic [OCNT_W-1:0] count;
    } list_result_t;

    // Shadow copy of the list plus the queue of results still owed by the block
    class list_scoreboard;
        logic [DATA_W-1:0] list_q[$];
        list_result_t      owed_q[$];
        int errors;
        int items_noted;
        int results_seen;
        int longest;
        int status_hits[4];

        task report_mismatch(input string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t: mismatch: %s", $realtime, msg);
        endtask

        function void note_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
            list_result_t r;
            int cnt;
            cnt = list_q.size();
            r.data = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_INSERT: begin
                    if (pos == 0 || pos > cnt + 1)
                        r.status = ST_INVALID;
                    else if (cnt >= DEPTH)
                        r.status = ST_FULL;
                    else
                        list_q.insert(pos - 1, val);
                end
                CMD_DELETE, CMD_READ: begin
                    // empty check wins over the position check
                    if (cnt == 0)
                        r.status = ST_EMPTY;
                    else if (pos == 0 || pos > cnt)
                        r.status = ST_INVALID;
                    else begin
                        r.data = list_q[pos - 1];
                        if (cmd == CMD_DELETE)
                            list_q.delete(pos - 1);
                    end
                end
                default: r.status = ST_INVALID;
            endcase
            r.count = OCNT_W'(list_q.size());
            if (list_q.size() > longest)
                longest = list_q.size();
            status_hits[r.status]++;
            items_noted++;
            owed_q.push_back(r);
        endfunction

        task check_result(input logic [DATA_W-1:0] d, input logic [1:0] st,
                          input logic [OCNT_W-1:0] c);
            list_result_t e;
            results_seen++;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: data %0h status %0d count %0d",
                                          d, st, c));
            end
            else begin
                e = owed_q.pop_front();
                if (d !== e.data)
                    report_mismatch($sformatf("data %0h, want %0h", d, e.data));
                if (st !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d", st, e.status));
                if (c !== e.count)
                    report_mismatch($sformatf("count %0d, want %0d", c, e.count));
            end
        endtask
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [CMD_W-1:0]  command   = CMD_INSERT;
    logic [POS_W-1:0]  position  = '0;
    logic [DATA_W-1:0] value     = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [DATA_W-1:0] data;
    logic [1:0]        status;
    logic [OCNT_W-1:0] count;

    list_scoreboard sb = new();
    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;
    int idle_cycles = 0;

    positional_list_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data      (data),
        .status    (status),
        .count     (count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        position <= pos;
        value    <= val;
        do @(posedge clk); while (!in_ready);
        sb.note_item(cmd, pos, val);
    endtask

    // ins_pct biases the list towards filling up or draining
    task automatic run_phase(input int n, input int ins_pct);
        int roll;
        int cnt;
        int hi;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        repeat (n)
        begin
            cnt = sb.list_q.size();
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = CMD_UNKNOWN;
            else if (roll < 3 + ins_pct)
                cmd = CMD_INSERT;
            else if ($urandom_range(0, 1) == 0)
                cmd = CMD_DELETE;
            else
                cmd = CMD_READ;
            hi = (cmd == CMD_INSERT) ? cnt + 1 : ((cnt == 0) ? 1 : cnt);
            roll = $urandom_range(0, 9);
            if (roll == 0)
                pos = '0;
            else if (roll == 1)
                pos = POS_W'($urandom_range(0, 127));
            else
                pos = POS_W'($urandom_range(1, hi));
            send_item(cmd, pos, DATA_W'($urandom));
        end
    endtask

    // receiver: a fresh stall for every result
    initial
    begin
        int stall;
        forever
        begin
            stall = out_calm ? 0 : $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(data, status, count);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, bad positions, ends and middle, unknown command
        send_item(CMD_READ,    7'd1,   8'h11);
        send_item(CMD_DELETE,  7'd3,   8'h22);
        send_item(CMD_INSERT,  7'd0,   8'h33);
        send_item(CMD_INSERT,  7'd2,   8'h44);
        send_item(CMD_INSERT,  7'd1,   8'h00);
        send_item(CMD_INSERT,  7'd2,   8'hFF);
        send_item(CMD_INSERT,  7'd1,   8'h5A);
        send_item(CMD_INSERT,  7'd2,   8'hA5);
        send_item(CMD_INSERT,  7'd5,   8'h7F);
        send_item(CMD_INSERT,  7'd127, 8'h80);
        send_item(CMD_READ,    7'd0,   8'h00);
        send_item(CMD_READ,    7'd6,   8'h00);
        send_item(CMD_READ,    7'd127, 8'hFF);
        send_item(CMD_UNKNOWN, 7'd1,   8'hFF);
        send_item(CMD_READ,    7'd1,   8'h00);
        send_item(CMD_READ,    7'd5,   8'h00);
        send_item(CMD_DELETE,  7'd0,   8'h00);
        send_item(CMD_DELETE,  7'd3,   8'h00);
        send_item(CMD_DELETE,  7'd1,   8'h00);
        send_item(CMD_DELETE,  7'd3,   8'h00);
        send_item(CMD_DELETE,  7'd1,   8'h00);
        send_item(CMD_DELETE,  7'd1,   8'h00);
        send_item(CMD_READ,    7'd1,   8'h00);

        // random: fill phases run into the full limit, drain phases back to empty
        run_phase(200, 80);
        run_phase(150, 45);
        run_phase(200, 15);
        run_phase(250, 85);
        run_phase(150, 45);
        run_phase(150, 12);
        run_phase(150, 50);

        in_valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.owed_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.owed_q.size()));

        $display("covered %0d items, %0d results, longest list %0d of %0d",
                 sb.items_noted, sb.results_seen, sb.longest, DEPTH);
        $display("status mix: ok %0d, empty %0d, invalid %0d, full %0d, mismatches %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY],
                 sb.status_hits[ST_INVALID], sb.status_hits[ST_FULL], sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/ple_decode.sv
hdl/positional_list_engine_top.sv
hdl/ple_checker.sv
tb/testbench.sv
